### rtl/core/ecb_pkg.sv
// Shared constants, types and register codes for the edge-triggered capture buffer.
package ecb_pkg;

   localparam int DEPTH    = 1024;
   localparam int CHANNELS = 8;
   localparam int DATA_W   = 32;
   localparam int IDX_W    = $clog2(DEPTH);
   localparam int ROWS_W   = $clog2(DEPTH + 1);
   localparam int CH_W     = 3;
   localparam int ROW_W    = CHANNELS * DATA_W;
   localparam int CSR_IDX_W = 3;

   typedef logic [1:0]              opcode_type;
   typedef logic signed [DATA_W-1:0] sample_type;
   typedef logic [IDX_W-1:0]        row_index_type;
   typedef logic [ROWS_W-1:0]       row_count_type;
   typedef logic [CH_W-1:0]         channel_type;
   typedef logic [CHANNELS-1:0][DATA_W-1:0] row_type;

   localparam opcode_type OP_ARM  = 2'd0;
   localparam opcode_type OP_SCAN = 2'd1;
   localparam opcode_type OP_READ = 2'd2;
   localparam opcode_type OP_STOP = 2'd3;

   localparam logic [CSR_IDX_W-1:0] CSR_CAPTURE_MODE    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_TRIGGER_MODE    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_TRIGGER_LEVEL   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_TRIGGER_CHANNEL = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_ROWS_IN_USE     = 3'd4;

   localparam logic [1:0] TRIG_IMMEDIATE = 2'd0;
   localparam logic [1:0] TRIG_RISING    = 2'd1;
   localparam logic [1:0] TRIG_FALLING   = 2'd2;
   localparam logic [1:0] TRIG_BOTH      = 2'd3;

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_READ = 2'b10
   } state_type;

endpackage

### rtl/core/ecb_req_if.sv
// Request channel: valid/ready handshake with one capture command item.
interface ecb_req_if;
   logic                valid;
   logic                ready;
   ecb_pkg::opcode_type opcode;
   ecb_pkg::sample_type sample_0;
   ecb_pkg::sample_type sample_1;
   ecb_pkg::sample_type sample_2;
   ecb_pkg::sample_type sample_3;
   ecb_pkg::sample_type sample_4;
   ecb_pkg::sample_type sample_5;
   ecb_pkg::sample_type sample_6;
   ecb_pkg::sample_type sample_7;
   logic [9:0]          read_row;
   ecb_pkg::channel_type read_channel;

   modport source (output valid, opcode, sample_0, sample_1, sample_2, sample_3,
                   sample_4, sample_5, sample_6, sample_7, read_row, read_channel,
                   input ready);
   modport sink   (input valid, opcode, sample_0, sample_1, sample_2, sample_3,
                   sample_4, sample_5, sample_6, sample_7, read_row, read_channel,
                   output ready);
endinterface

### rtl/core/ecb_rsp_if.sv
// Response channel: valid/ready handshake with one status and read-data item.
interface ecb_rsp_if;
   logic                   valid;
   logic                   ready;
   ecb_pkg::sample_type    read_data;
   logic                   capturing;
   logic                   waiting_trigger;
   logic                   row_written;
   ecb_pkg::row_count_type rows_captured;

   modport source (output valid, read_data, capturing, waiting_trigger, row_written,
                   rows_captured, input ready);
   modport sink   (input valid, read_data, capturing, waiting_trigger, row_written,
                   rows_captured, output ready);
endinterface

### rtl/core/ecb_ram.sv
// Generic single-write, single-read RAM with registered read data.
module ecb_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

### rtl/core/edge_triggered_capture_buffer_unit.sv
// Edge-triggered circular capture buffer: trigger logic, ring pointers and row store.
// Results: arm, scan and stop items answer in the cycle after acceptance; a read item's
//   answer passes the row store read register and then the output register.
// Flow: 1 item per cycle for arm, scan and stop while the response channel is not stalled;
//   after a read item the request channel is not ready until the row store has answered.
// Reset: control, pointers and configuration clear at once; payload registers are not
//   reset; the row store is not cleared and holds no valid bits, so needs no clearing.
module edge_triggered_capture_buffer_unit (
   input  logic                              clock,
   input  logic                              reset,
   ecb_req_if.sink                           req_ch,
   ecb_rsp_if.source                         rsp_ch,
   input  logic                              csr_we,
   input  logic [ecb_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [ecb_pkg::DATA_W-1:0]        csr_wdata
);

   // Configuration registers
   logic                   capture_mode_ff;
   logic [1:0]             trigger_mode_ff;
   ecb_pkg::sample_type    trigger_level_ff;
   ecb_pkg::channel_type   trigger_channel_ff;
   ecb_pkg::row_count_type rows_in_use_ff;

   // Capture state
   ecb_pkg::row_index_type write_index_ff, write_index_in;
   ecb_pkg::row_index_type oldest_index_ff, oldest_index_in;
   ecb_pkg::row_count_type row_count_ff, row_count_in;
   logic                   running_ff, running_in;
   logic                   waiting_ff, waiting_in;
   ecb_pkg::sample_type    previous_sync_ff, previous_sync_in;
   ecb_pkg::state_type     state_ff, state_in;

   // Pending read
   logic                   rd_ok_ff, rd_ok_in;
   ecb_pkg::channel_type   rd_ch_ff, rd_ch_in;

   // Output register
   logic                   rsp_valid_ff, rsp_valid_in;
   ecb_pkg::sample_type    rsp_data_ff, rsp_data_in;
   logic                   rsp_run_ff, rsp_run_in;
   logic                   rsp_wait_ff, rsp_wait_in;
   logic                   rsp_wrote_ff, rsp_wrote_in;
   ecb_pkg::row_count_type rsp_count_ff, rsp_count_in;

   // Row store ports
   logic                   mem_we;
   ecb_pkg::row_index_type mem_waddr;
   ecb_pkg::row_index_type mem_raddr;
   logic [ecb_pkg::ROW_W-1:0] mem_rdata;

   ecb_pkg::row_type       req_row;
   ecb_pkg::row_type       rd_row;
   ecb_pkg::row_count_type rows_eff;
   ecb_pkg::sample_type    sync_now;
   logic                   accept;
   logic                   rsp_free;
   logic                   ring_clear;

   // Pack the request samples into one memory row, channel 0 in the low word
   assign req_row = {req_ch.sample_7, req_ch.sample_6, req_ch.sample_5, req_ch.sample_4,
                     req_ch.sample_3, req_ch.sample_2, req_ch.sample_1, req_ch.sample_0};
   assign rd_row  = mem_rdata;

   // Saturate the ring size to [2, DEPTH]
   always_comb begin
      if (rows_in_use_ff < ecb_pkg::ROWS_W'(2)) begin
         rows_eff = ecb_pkg::ROWS_W'(2);
      end else if (rows_in_use_ff > ecb_pkg::ROWS_W'(ecb_pkg::DEPTH)) begin
         rows_eff = ecb_pkg::ROWS_W'(ecb_pkg::DEPTH);
      end else begin
         rows_eff = rows_in_use_ff;
      end
   end

   // Watched channel; a channel beyond the row reads as zero
   always_comb begin
      if ({1'b0, trigger_channel_ff} < (ecb_pkg::CH_W + 1)'(ecb_pkg::CHANNELS)) begin
         sync_now = req_row[trigger_channel_ff];
      end else begin
         sync_now = '0;
      end
   end

   assign rsp_free     = !rsp_valid_ff || rsp_ch.ready;
   assign req_ch.ready = (state_ff == ecb_pkg::ST_IDLE) && rsp_free;
   assign accept       = req_ch.valid && req_ch.ready;

   // A new ring size drops the captured rows
   assign ring_clear   = csr_we && (csr_index == ecb_pkg::CSR_ROWS_IN_USE);

   // Read address: oldest row plus logical row, wrapped once at the ring size
   always_comb begin
      logic [ecb_pkg::ROWS_W:0] phys;
      phys = (ecb_pkg::ROWS_W + 1)'(oldest_index_ff) + (ecb_pkg::ROWS_W + 1)'(req_ch.read_row);
      if (phys >= (ecb_pkg::ROWS_W + 1)'(rows_eff)) begin
         phys = phys - (ecb_pkg::ROWS_W + 1)'(rows_eff);
      end
      mem_raddr = phys[ecb_pkg::IDX_W-1:0];
   end

   // Item processing
   always_comb begin
      logic                   trig_hit;
      logic                   rise;
      logic                   fall;
      logic                   wait_now;
      ecb_pkg::row_count_type w_eff;
      ecb_pkg::row_count_type w_next;
      ecb_pkg::row_count_type cnt_next;

      write_index_in   = write_index_ff;
      oldest_index_in  = oldest_index_ff;
      row_count_in     = row_count_ff;
      running_in       = running_ff;
      waiting_in       = waiting_ff;
      previous_sync_in = previous_sync_ff;
      state_in         = state_ff;
      rd_ok_in         = rd_ok_ff;
      rd_ch_in         = rd_ch_ff;
      rsp_valid_in     = rsp_valid_ff && !rsp_ch.ready;
      rsp_data_in      = rsp_data_ff;
      rsp_run_in       = rsp_run_ff;
      rsp_wait_in      = rsp_wait_ff;
      rsp_wrote_in     = rsp_wrote_ff;
      rsp_count_in     = rsp_count_ff;
      mem_we           = 1'b0;
      mem_waddr        = write_index_ff;

      rise     = (previous_sync_ff < trigger_level_ff) && (sync_now >= trigger_level_ff);
      fall     = (previous_sync_ff > trigger_level_ff) && (sync_now <= trigger_level_ff);
      trig_hit = 1'b0;
      case (trigger_mode_ff)
         ecb_pkg::TRIG_IMMEDIATE: trig_hit = 1'b1;
         ecb_pkg::TRIG_RISING:    trig_hit = rise;
         ecb_pkg::TRIG_FALLING:   trig_hit = fall;
         default:                 trig_hit = rise || fall;
      endcase
      wait_now = waiting_ff && !trig_hit;

      // Wrap the write pointer into the current ring before and after the write
      w_eff = ecb_pkg::ROWS_W'(write_index_ff);
      if (w_eff >= rows_eff) begin
         w_eff = '0;
      end
      w_next = w_eff + ecb_pkg::ROWS_W'(1);
      if (w_next >= rows_eff) begin
         w_next = '0;
      end
      cnt_next = row_count_ff + ecb_pkg::ROWS_W'(1);

      unique case (state_ff)
         ecb_pkg::ST_IDLE: begin
            if (accept) begin
               rsp_data_in  = '0;
               rsp_wrote_in = 1'b0;
               unique case (req_ch.opcode)
                  ecb_pkg::OP_ARM: begin
                     previous_sync_in = sync_now;
                     waiting_in       = (trigger_mode_ff != ecb_pkg::TRIG_IMMEDIATE);
                     write_index_in   = '0;
                     oldest_index_in  = '0;
                     row_count_in     = '0;
                     running_in       = 1'b1;
                  end
                  ecb_pkg::OP_SCAN: begin
                     previous_sync_in = sync_now;
                     if (running_ff) begin
                        waiting_in = wait_now;
                        if (!wait_now) begin
                           // Store the row and advance the ring
                           mem_we         = 1'b1;
                           mem_waddr      = w_eff[ecb_pkg::IDX_W-1:0];
                           rsp_wrote_in   = 1'b1;
                           write_index_in = w_next[ecb_pkg::IDX_W-1:0];
                           row_count_in   = cnt_next;
                           if (cnt_next >= rows_eff) begin
                              row_count_in    = rows_eff;
                              oldest_index_in = w_next[ecb_pkg::IDX_W-1:0];
                              if (capture_mode_ff) begin
                                 running_in = 1'b0;
                              end
                           end
                        end
                     end
                  end
                  ecb_pkg::OP_READ: begin
                     // Hold off new requests until the row store answers
                     rd_ok_in = ({1'b0, req_ch.read_row} < row_count_ff)
                                && (row_count_ff <= rows_eff)
                                && ({1'b0, req_ch.read_channel}
                                    < (ecb_pkg::CH_W + 1)'(ecb_pkg::CHANNELS));
                     rd_ch_in = req_ch.read_channel;
                     state_in = ecb_pkg::ST_READ;
                  end
                  default: begin
                     running_in = 1'b0;
                     waiting_in = 1'b0;
                  end
               endcase
               if (req_ch.opcode != ecb_pkg::OP_READ) begin
                  rsp_valid_in = 1'b1;
                  rsp_run_in   = (req_ch.opcode == ecb_pkg::OP_SCAN) ? running_in
                               : (req_ch.opcode == ecb_pkg::OP_ARM);
                  rsp_wait_in  = (req_ch.opcode == ecb_pkg::OP_STOP) ? 1'b0 : waiting_in;
                  rsp_count_in = row_count_in;
               end
            end
         end
         ecb_pkg::ST_READ: begin
            // The output register was freed when the read was accepted
            rsp_valid_in = 1'b1;
            rsp_data_in  = rd_ok_ff ? rd_row[rd_ch_ff] : '0;
            rsp_run_in   = running_ff;
            rsp_wait_in  = waiting_ff;
            rsp_wrote_in = 1'b0;
            rsp_count_in = row_count_ff;
            state_in     = ecb_pkg::ST_IDLE;
         end
         default: begin
            state_in = ecb_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         capture_mode_ff    <= 1'b0;
         trigger_mode_ff    <= ecb_pkg::TRIG_IMMEDIATE;
         trigger_level_ff   <= '0;
         trigger_channel_ff <= '0;
         rows_in_use_ff     <= ecb_pkg::ROWS_W'(ecb_pkg::DEPTH);
         write_index_ff     <= '0;
         oldest_index_ff    <= '0;
         row_count_ff       <= '0;
         running_ff         <= 1'b0;
         waiting_ff         <= 1'b0;
         previous_sync_ff   <= '0;
         state_ff           <= ecb_pkg::ST_IDLE;
         rsp_valid_ff       <= 1'b0;
      end else begin
         running_ff       <= running_in;
         waiting_ff       <= waiting_in;
         previous_sync_ff <= previous_sync_in;
         state_ff         <= state_in;
         rsp_valid_ff     <= rsp_valid_in;
         if (ring_clear) begin
            write_index_ff  <= '0;
            oldest_index_ff <= '0;
            row_count_ff    <= '0;
         end else begin
            write_index_ff  <= write_index_in;
            oldest_index_ff <= oldest_index_in;
            row_count_ff    <= row_count_in;
         end
         if (csr_we) begin
            unique case (csr_index)
               ecb_pkg::CSR_CAPTURE_MODE:    capture_mode_ff    <= csr_wdata[0];
               ecb_pkg::CSR_TRIGGER_MODE:    trigger_mode_ff    <= csr_wdata[1:0];
               ecb_pkg::CSR_TRIGGER_LEVEL:   trigger_level_ff   <= csr_wdata;
               ecb_pkg::CSR_TRIGGER_CHANNEL: trigger_channel_ff <= csr_wdata[ecb_pkg::CH_W-1:0];
               ecb_pkg::CSR_ROWS_IN_USE:     rows_in_use_ff     <= csr_wdata[ecb_pkg::ROWS_W-1:0];
               default: ;
            endcase
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      rd_ok_ff     <= rd_ok_in;
      rd_ch_ff     <= rd_ch_in;
      rsp_data_ff  <= rsp_data_in;
      rsp_run_ff   <= rsp_run_in;
      rsp_wait_ff  <= rsp_wait_in;
      rsp_wrote_ff <= rsp_wrote_in;
      rsp_count_ff <= rsp_count_in;
   end

   ecb_ram #(
      .WIDTH (ecb_pkg::ROW_W),
      .DEPTH (ecb_pkg::DEPTH)
   ) u_row_store (
      .clock (clock),
      .we    (mem_we),
      .waddr (mem_waddr),
      .wdata (req_row),
      .raddr (mem_raddr),
      .rdata (mem_rdata)
   );

   assign rsp_ch.valid           = rsp_valid_ff;
   assign rsp_ch.read_data       = rsp_data_ff;
   assign rsp_ch.capturing       = rsp_run_ff;
   assign rsp_ch.waiting_trigger = rsp_wait_ff;
   assign rsp_ch.row_written     = rsp_wrote_ff;
   assign rsp_ch.rows_captured   = rsp_count_ff;

endmodule
